// ----- src/gregorian_date_difference_unit_macros.svh -----
// Assertion macros shared by the date difference checker
`ifndef GREGORIAN_DATE_DIFFERENCE_UNIT_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_UNIT_MACROS_SVH

// Expression must hold at every clock edge out of reset
`define GDD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("gdd check failed: expression does not hold");

// Antecedent implies consequent at the same edge
`define GDD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdd check failed: implication does not hold");

`endif

// ----- src/gdd_pkg.sv -----
// Shared types, constants and calendar tables of the date difference unit
package gdd_pkg;

   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int DAY_NUM_W   = 23;
   localparam int DIFF_W      = 24;
   localparam int STATUS_W    = 3;
   localparam int DB_W        = 9;

   // floor(n / 100) == (n * RECIP_100) >> RECIP_SHIFT for every 14-bit n
   localparam int RECIP_100   = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int Q100_W      = PROD_W - RECIP_SHIFT;

   localparam int DAYS_COMMON = 365;
   localparam int CENTURY     = 100;
   localparam int MONTHS      = 12;
   localparam int CUTOFF_YEAR  = 1582;
   localparam int CUTOFF_MONTH = 10;
   localparam int CUTOFF_DAY   = 15;

   // Depth of the valid pipe to the output register
   localparam int PIPE_DEPTH  = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_VALID     = 3'd0,
      ST_DAY_ZERO  = 3'd1,
      ST_BAD_MONTH = 3'd2,
      ST_DAY_LARGE = 3'd3,
      ST_PRE_GREG  = 3'd4
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [DAY_NUM_W-1:0]   day_num;
   } date_result_type;

   function automatic logic [DAY_W-1:0] month_length(input logic leap,
                                                     input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [DB_W-1:0] days_before(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
      logic [DB_W-1:0] db;
      unique case (month)
         4'd2:    db = 9'd31;
         4'd3:    db = 9'd59;
         4'd4:    db = 9'd90;
         4'd5:    db = 9'd120;
         4'd6:    db = 9'd151;
         4'd7:    db = 9'd181;
         4'd8:    db = 9'd212;
         4'd9:    db = 9'd243;
         4'd10:   db = 9'd273;
         4'd11:   db = 9'd304;
         4'd12:   db = 9'd334;
         default: db = 9'd0;
      endcase
      // leap day counts from March on
      if (leap && month > 4'd2) begin
         db = db + 9'd1;
      end
      return db;
   endfunction

endpackage

// ----- src/gdd_day_number.sv -----
// Three-stage day number and validity pipeline for one calendar date
module gdd_day_number (
   input  logic                           clock,
   input  logic [gdd_pkg::DAY_W-1:0]      date_day,
   input  logic [gdd_pkg::MONTH_W-1:0]    date_month,
   input  logic [gdd_pkg::YEAR_W-1:0]     date_year,
   output gdd_pkg::date_result_type       result
);
   import gdd_pkg::*;

   // stage A: year minus one and its quotient by 100
   logic [DAY_W-1:0]      a_day_ff;
   logic [MONTH_W-1:0]    a_month_ff;
   logic [YEAR_W-1:0]     a_year_ff;
   logic [YEAR_W-1:0]     a_py_ff;
   logic [Q100_W-1:0]     a_q100_ff;
   logic [YEAR_W-1:0]     a_py_in;
   logic [PROD_W-1:0]     a_prod;

   // stage B: leap flag and day count of the whole years before
   logic [DAY_W-1:0]      b_day_ff;
   logic [MONTH_W-1:0]    b_month_ff;
   logic [YEAR_W-1:0]     b_year_ff;
   logic                  b_leap_ff;
   logic [DAY_NUM_W-1:0]  b_base_ff;
   logic                  b_leap_in;
   logic [DAY_NUM_W-1:0]  b_base_in;
   logic [YEAR_W-1:0]     b_rem100;
   logic [YEAR_W-1:0]     b_leaps;

   // stage C: status and day number
   date_result_type       c_result_ff;
   date_result_type       c_result_in;
   logic                  c_pre_greg;

   always_comb begin
      a_py_in = date_year - YEAR_W'(1);
      a_prod  = PROD_W'(a_py_in) * PROD_W'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      a_day_ff   <= date_day;
      a_month_ff <= date_month;
      a_year_ff  <= date_year;
      a_py_ff    <= a_py_in;
      a_q100_ff  <= a_prod[RECIP_SHIFT +: Q100_W];
   end

   always_comb begin
      b_rem100 = a_py_ff - YEAR_W'(a_q100_ff) * YEAR_W'(CENTURY);
      // year divisible by 4; by 100 when py mod 100 is 99, then by 400 via quotient
      b_leap_in = (a_py_ff[1:0] == 2'b11) &&
                  ((b_rem100 != YEAR_W'(CENTURY - 1)) || (a_q100_ff[1:0] == 2'b11));
      b_leaps   = (a_py_ff >> 2) - YEAR_W'(a_q100_ff) + YEAR_W'(a_q100_ff >> 2);
      b_base_in = DAY_NUM_W'(a_py_ff) * DAY_NUM_W'(DAYS_COMMON) + DAY_NUM_W'(b_leaps);
   end

   always_ff @(posedge clock) begin
      b_day_ff   <= a_day_ff;
      b_month_ff <= a_month_ff;
      b_year_ff  <= a_year_ff;
      b_leap_ff  <= b_leap_in;
      b_base_ff  <= b_base_in;
   end

   always_comb begin
      c_pre_greg = (b_year_ff < YEAR_W'(CUTOFF_YEAR)) ||
                   ((b_year_ff == YEAR_W'(CUTOFF_YEAR)) &&
                    ((b_month_ff < MONTH_W'(CUTOFF_MONTH)) ||
                     ((b_month_ff == MONTH_W'(CUTOFF_MONTH)) &&
                      (b_day_ff < DAY_W'(CUTOFF_DAY)))));
      priority if (b_day_ff == '0) begin
         c_result_in.status = ST_DAY_ZERO;
      end else if (b_month_ff == '0 || b_month_ff > MONTH_W'(MONTHS)) begin
         c_result_in.status = ST_BAD_MONTH;
      end else if (b_day_ff > month_length(b_leap_ff, b_month_ff)) begin
         c_result_in.status = ST_DAY_LARGE;
      end else if (c_pre_greg) begin
         c_result_in.status = ST_PRE_GREG;
      end else begin
         c_result_in.status = ST_VALID;
      end
      c_result_in.day_num = b_base_ff + DAY_NUM_W'(days_before(b_leap_ff, b_month_ff)) +
                            DAY_NUM_W'(b_day_ff);
   end

   always_ff @(posedge clock) begin
      c_result_ff <= c_result_in;
   end

   assign result = c_result_ff;

endmodule

// ----- src/gregorian_date_difference_unit.sv -----
// Top level: signed day count between two Gregorian dates with date checks
//
//   channel   ports                              handshake
//   request   req_start_*, req_end_*             start high, busy low
//   response  rsp_day_difference, rsp_*_status   rsp_valid strobe, one cycle
//
// One pair of dates is taken every cycle; busy stays low.
// The pipe holds three day number stages per date, then the subtract.
// The depth is set by the reciprocal multiply for the century count and the
// 365 scaling, each with a register behind it.
// Reset clears the valid pipe only; the data registers are not reset.
module gregorian_date_difference_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [gdd_pkg::DAY_W-1:0]            req_start_day,
   input  logic [gdd_pkg::MONTH_W-1:0]          req_start_month,
   input  logic [gdd_pkg::YEAR_W-1:0]           req_start_year,
   input  logic [gdd_pkg::DAY_W-1:0]            req_end_day,
   input  logic [gdd_pkg::MONTH_W-1:0]          req_end_month,
   input  logic [gdd_pkg::YEAR_W-1:0]           req_end_year,
   output logic                                 rsp_valid,
   output logic signed [gdd_pkg::DIFF_W-1:0]    rsp_day_difference,
   output logic [gdd_pkg::STATUS_W-1:0]         rsp_start_status,
   output logic [gdd_pkg::STATUS_W-1:0]         rsp_end_status
);
   import gdd_pkg::*;

   logic [PIPE_DEPTH-1:0]      valid_ff;
   logic [PIPE_DEPTH-1:0]      valid_in;
   date_result_type            start_result;
   date_result_type            end_result;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [DIFF_W-1:0]   diff_in;
   status_type                 start_status_ff;
   status_type                 end_status_ff;

   gdd_day_number u_start_date (
      .clock      (clock),
      .date_day   (req_start_day),
      .date_month (req_start_month),
      .date_year  (req_start_year),
      .result     (start_result)
   );

   gdd_day_number u_end_date (
      .clock      (clock),
      .date_day   (req_end_day),
      .date_month (req_end_month),
      .date_year  (req_end_year),
      .result     (end_result)
   );

   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], start};
      // drop the difference when either date fails its checks
      if (start_result.status == ST_VALID && end_result.status == ST_VALID) begin
         diff_in = DIFF_W'(end_result.day_num) - DIFF_W'(start_result.day_num);
      end else begin
         diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff         <= diff_in;
      start_status_ff <= start_result.status;
      end_status_ff   <= end_result.status;
   end

   assign busy               = 1'b0;
   assign rsp_valid          = valid_ff[PIPE_DEPTH-1];
   assign rsp_day_difference = diff_ff;
   assign rsp_start_status   = start_status_ff;
   assign rsp_end_status     = end_status_ff;

endmodule

// ----- src/gdd_checker.sv -----
// Port-level checker for the date difference unit, bound to the top level
`include "gregorian_date_difference_unit_macros.svh"

module gdd_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic                                 rsp_valid,
   input  logic signed [gdd_pkg::DIFF_W-1:0]    rsp_day_difference,
   input  logic [gdd_pkg::STATUS_W-1:0]         rsp_start_status,
   input  logic [gdd_pkg::STATUS_W-1:0]         rsp_end_status
);
   import gdd_pkg::*;

   logic                  accept;
   logic [PIPE_DEPTH-1:0] accept_hist_ff;
   logic                  accept_d4;
   logic                  any_invalid;
   logic                  status_ok;

   assign accept      = start && !busy;

   // track accepted items over the pipeline depth
   always_ff @(posedge clock) begin
      if (reset) begin
         accept_hist_ff <= '0;
      end else begin
         accept_hist_ff <= {accept_hist_ff[PIPE_DEPTH-2:0], accept};
      end
   end

   assign accept_d4   = accept_hist_ff[PIPE_DEPTH-1];
   assign any_invalid = (rsp_start_status != ST_VALID) || (rsp_end_status != ST_VALID);
   assign status_ok   = (rsp_start_status <= ST_PRE_GREG) && (rsp_end_status <= ST_PRE_GREG);

   `GDD_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `GDD_ASSERT_IMPL(a_rsp_from_accept, clock, reset, rsp_valid, accept_d4)
   `GDD_ASSERT_IMPL(a_invalid_zero_diff, clock, reset, rsp_valid && any_invalid, rsp_day_difference == '0)
   `GDD_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, status_ok)

endmodule

bind gregorian_date_difference_unit gdd_checker u_gdd_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_day_difference (rsp_day_difference),
   .rsp_start_status   (rsp_start_status),
   .rsp_end_status     (rsp_end_status)
);
